// File: sv/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants for the texel dilation fill block.
// ----------------------------------------------------------------------------
package tdf_pkg;

  localparam int unsigned MAX_TEXELS_DEF = 65536;
  localparam int unsigned MAX_RADIUS_DEF = 7;

  localparam logic [8:0]  WIDTH_RST  = 9'd256;
  localparam logic [8:0]  HEIGHT_RST = 9'd256;
  localparam logic [2:0]  RADIUS_RST = 3'd2;
  localparam logic [15:0] THRESH_RST = 16'd32440;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SELF_RD,
    ST_SELF_CHK,
    ST_DIVMOD,
    ST_NB_ISSUE,
    ST_NB_WAIT,
    ST_NB_ACC,
    ST_DIV,
    ST_OUT
  } tdf_state_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } texel_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic        was_filled;
  } result_t;

  // divider request / response
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quo;
  } div_rsp_t;

endpackage

// File: sv/tdf_ram.sv
// ----------------------------------------------------------------------------
// tdf_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module tdf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/tdf_div.sv
// ----------------------------------------------------------------------------
// tdf_div
// Rounded, saturated restoring divider: round(num / den), max 65535.
// Computes floor((2*num + den) / (2*den)), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdf_div
  import tdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NW = 50;

  logic [NW-1:0] n_r, n_nxt;
  logic [NW:0]   rem_r, rem_nxt;
  logic [33:0]   d_r, d_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW:0]   shl;

  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shl      = {rem_r[NW-1:0], n_r[NW-1]};
    if (req.start) begin
      n_nxt    = {1'b0, req.num, 1'b0} + {18'd0, req.den};
      d_nxt    = {1'b0, req.den, 1'b0};
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = 6'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[NW-2:0], 1'b0};
      if (shl >= {{(NW-33){1'b0}}, d_r}) begin
        rem_nxt = shl - {{(NW-33){1'b0}}, d_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shl;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = (q_r[NW-1:16] != '0) ? 16'hFFFF : q_r[15:0];

endmodule

// File: sv/tdf_ctrl.sv
// ----------------------------------------------------------------------------
// tdf_ctrl
// Query sequencer: self read, position split, window walk, four divisions.
// ----------------------------------------------------------------------------
module tdf_ctrl
  import tdf_pkg::*;
#(
  parameter int unsigned MAX_TEXELS = MAX_TEXELS_DEF,
  parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF,
  localparam int AW = $clog2(MAX_TEXELS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          func,
  input  logic [15:0]   texel_index,
  input  texel_t        in_texel,
  input  logic [8:0]    image_width,
  input  logic [8:0]    image_height,
  input  logic [2:0]    window_radius,
  input  logic [15:0]   cover_threshold,
  output logic          ram_we,
  output logic [AW-1:0] ram_addr,
  output texel_t        ram_wdata,
  input  texel_t        ram_rdata,
  output div_req_t      div_req,
  input  div_rsp_t      div_rsp,
  output logic          res_valid,
  input  logic          res_ready,
  output result_t       res_data
);

  localparam int unsigned RLIM = (MAX_RADIUS > 7) ? 7 : MAX_RADIUS;

  tdf_state_t state_r, state_nxt;

  logic [15:0] idx_r;
  logic [8:0]  w_r, h_r;
  logic [3:0]  rad_r;
  logic [15:0] px_r, py_r;
  logic [4:0]  dx_r, dy_r;
  logic [9:0]  nx_r, ny_r;
  logic [16:0] nidx;
  logic        nok_r;
  logic [23:0] cs_r [3];
  logic [23:0] cs_nxt [3];
  logic [23:0] as_r, as_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        hit;
  logic [1:0]  dsel_r;
  result_t     res_r;
  logic        res_v_r;
  logic        acc;

  logic [8:0]  w_c, h_c;
  logic [3:0]  r_c;
  logic [16:0] area;
  logic [9:0]  x_s, y_s;
  logic        dx_last, dy_last;

  always_comb begin
    w_c = (image_width == 9'd0) ? 9'd1 : (image_width > 9'd256 ? 9'd256 : image_width);
    h_c = (image_height == 9'd0) ? 9'd1 : (image_height > 9'd256 ? 9'd256 : image_height);
    r_c = ({1'b0, window_radius} > 4'(RLIM)) ? 4'(RLIM) : {1'b0, window_radius};
  end

  assign area    = 17'(w_r) * 17'(h_r);
  assign dx_last = (dx_r == 5'(2 * rad_r));
  assign dy_last = (dy_r == 5'(2 * rad_r));
  assign x_s     = 10'(px_r) + 10'(dx_r) - 10'(rad_r);
  assign y_s     = 10'(py_r) + 10'(dy_r) - 10'(rad_r);
  assign nidx    = 17'(ny_r[8:0]) * 17'(w_r) + 17'(nx_r[8:0]);

  assign in_tready = (state_r == ST_IDLE) && !res_v_r;
  assign acc       = in_tvalid && in_tready;

  // window sums including the texel read in the accumulate state
  always_comb begin
    hit       = (state_r == ST_NB_ACC) && nok_r && (ram_rdata.alpha > cover_threshold);
    cs_nxt[0] = cs_r[0] + (hit ? 24'(ram_rdata.red) : 24'd0);
    cs_nxt[1] = cs_r[1] + (hit ? 24'(ram_rdata.green) : 24'd0);
    cs_nxt[2] = cs_r[2] + (hit ? 24'(ram_rdata.blue) : 24'd0);
    as_nxt    = as_r + (hit ? 24'(ram_rdata.alpha) : 24'd0);
    cnt_nxt   = cnt_r + (hit ? 8'd1 : 8'd0);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && func == FUNC_QUERY && (32'(texel_index) < MAX_TEXELS)) begin
          state_nxt = ST_SELF_RD;
        end
      end
      ST_SELF_RD:  state_nxt = ST_SELF_CHK;
      ST_SELF_CHK: begin
        if ({1'b0, idx_r} >= area || ram_rdata.alpha >= cover_threshold) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_DIVMOD;
        end
      end
      ST_DIVMOD:   if (px_r < {7'd0, w_r}) state_nxt = ST_NB_ISSUE;
      ST_NB_ISSUE: state_nxt = ST_NB_WAIT;
      ST_NB_WAIT:  state_nxt = ST_NB_ACC;
      ST_NB_ACC: begin
        if (dx_last && dy_last) begin
          state_nxt = (cnt_nxt != 8'd0 && as_nxt != 24'd0) ? ST_DIV : ST_OUT;
        end else begin
          state_nxt = ST_NB_ISSUE;
        end
      end
      ST_DIV:      if (div_rsp.done && dsel_r == 2'd3) state_nxt = ST_OUT;
      ST_OUT:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = acc && func == FUNC_WRITE && (32'(texel_index) < MAX_TEXELS);
    ram_wdata = in_texel;
    ram_addr  = AW'(texel_index);
    if (state_r == ST_NB_WAIT) begin
      ram_addr = AW'(nidx);
    end else if (state_r != ST_IDLE) begin
      ram_addr = AW'(idx_r);
    end
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {9'd0, cs_nxt[0], 15'd0};
    div_req.den   = {8'd0, as_nxt};
    unique case (dsel_r)
      2'd0: div_req.num = {9'd0, cs_nxt[0], 15'd0};
      2'd1: div_req.num = {9'd0, cs_nxt[1], 15'd0};
      2'd2: div_req.num = {9'd0, cs_nxt[2], 15'd0};
      2'd3: begin
        div_req.num = {24'd0, as_nxt};
        div_req.den = {24'd0, cnt_nxt};
      end
      default: ;
    endcase
    if (state_r == ST_NB_ACC && state_nxt == ST_DIV) div_req.start = 1'b1;
    if (state_r == ST_DIV && div_rsp.done && dsel_r != 2'd3) begin
      div_req.start = 1'b1;
      unique case (dsel_r)
        2'd0: div_req.num = {9'd0, cs_nxt[1], 15'd0};
        2'd1: div_req.num = {9'd0, cs_nxt[2], 15'd0};
        default: begin
          div_req.num = {24'd0, as_nxt};
          div_req.den = {24'd0, cnt_nxt};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      res_v_r <= 1'b0;
      dsel_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (res_v_r && res_ready) res_v_r <= 1'b0;
      if (acc && func == FUNC_QUERY && !(32'(texel_index) < MAX_TEXELS)) res_v_r <= 1'b1;
      if (state_r == ST_OUT) res_v_r <= 1'b1;
      if (state_r == ST_SELF_RD) dsel_r <= 2'd0;
      if (state_r == ST_DIV && div_rsp.done) dsel_r <= dsel_r + 2'd1;
    end

    if (acc) begin
      idx_r <= texel_index;
      w_r   <= w_c;
      h_r   <= h_c;
      rad_r <= r_c;
      if (func == FUNC_QUERY && !(32'(texel_index) < MAX_TEXELS)) res_r <= '0;
    end

    unique case (state_r)
      ST_SELF_CHK: begin
        res_r <= {ram_rdata.red, ram_rdata.green, ram_rdata.blue, ram_rdata.alpha, 1'b0};
        px_r  <= idx_r;
        py_r  <= '0;
        dx_r  <= '0;
        dy_r  <= '0;
        cs_r[0] <= '0; cs_r[1] <= '0; cs_r[2] <= '0;
        as_r  <= '0;
        cnt_r <= '0;
      end
      ST_DIVMOD: begin
        // repeated subtraction of the row width, row count below 256
        if (px_r >= {7'd0, w_r}) begin
          px_r <= px_r - {7'd0, w_r};
          py_r <= py_r + 16'd1;
        end
      end
      ST_NB_ISSUE: ;
      ST_NB_WAIT: ;
      ST_NB_ACC: begin
        cs_r[0] <= cs_nxt[0];
        cs_r[1] <= cs_nxt[1];
        cs_r[2] <= cs_nxt[2];
        as_r    <= as_nxt;
        cnt_r   <= cnt_nxt;
        if (dx_last) begin
          dx_r <= '0;
          dy_r <= dy_r + 5'd1;
        end else begin
          dx_r <= dx_r + 5'd1;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          unique case (dsel_r)
            2'd0: res_r.red   <= div_rsp.quo;
            2'd1: res_r.green <= div_rsp.quo;
            2'd2: res_r.blue  <= div_rsp.quo;
            default: begin
              res_r.alpha      <= div_rsp.quo;
              res_r.was_filled <= 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase

    // neighbour position settles in the issue state, read goes out in the wait state
    nx_r  <= x_s;
    ny_r  <= y_s;
    nok_r <= !nx_r[9] && !ny_r[9] && (nx_r < {1'b0, w_r}) && (ny_r < {1'b0, h_r})
             && (32'(nidx) < MAX_TEXELS);
  end

  assign res_valid = res_v_r;
  assign res_data  = res_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("accept while busy");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (state_r == ST_NB_ACC || state_r == ST_DIV)) else $error("stray div");
  a_out_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> res_v_r) else $error("result lost");
`endif

endmodule

// File: sv/texel_dilation_fill.sv
// ----------------------------------------------------------------------------
// texel_dilation_fill
// Lightmap texel store with dilation of uncovered texels by window average.
// ----------------------------------------------------------------------------
// channel | dir | contents
// in_     | in  | tuser: func; tdata: index, red, green, blue, alpha
// out_    | out | tuser: was_filled; tdata: red, green, blue, alpha
// cfg_    | in  | cfg_index (2b), cfg_data (16b)
// Write: stored when accepted. Query: self read and check, then the index is
// split by subtracting the row width once per image row above the texel, one
// RAM read per window texel and, for a filled query, four divisions.
// Reset: synchronous, active low; texel memory is not cleared.
// One item at a time; result held in the output register until taken.
// ----------------------------------------------------------------------------
module texel_dilation_fill
  import tdf_pkg::*;
#(
  parameter int unsigned MAX_TEXELS = MAX_TEXELS_DEF,
  parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // texel_index, in_red, in_green, in_blue, in_alpha
  input  logic         in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic         out_tuser,  // was_filled
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int AW = $clog2(MAX_TEXELS);

  logic [8:0]  width_r, height_r;
  logic [2:0]  radius_r;
  logic [15:0] thresh_r;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  texel_t        ram_wdata, ram_rdata, in_texel;
  div_req_t      div_req;
  div_rsp_t      div_rsp;
  result_t       res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      radius_r <= RADIUS_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[8:0];
        REG_HEIGHT: height_r <= cfg_data[8:0];
        REG_RADIUS: radius_r <= cfg_data[2:0];
        REG_THRESH: thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_texel = {in_tdata[79:64], in_tdata[63:48], in_tdata[47:32], in_tdata[31:16]};

  tdf_ram #(.WIDTH(64), .DEPTH(MAX_TEXELS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  tdf_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  tdf_ctrl #(.MAX_TEXELS(MAX_TEXELS), .MAX_RADIUS(MAX_RADIUS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .func(in_tuser), .texel_index(in_tdata[15:0]), .in_texel(in_texel),
    .image_width(width_r), .image_height(height_r),
    .window_radius(radius_r), .cover_threshold(thresh_r),
    .ram_we(ram_we), .ram_addr(ram_addr), .ram_wdata(ram_wdata), .ram_rdata(ram_rdata),
    .div_req(div_req), .div_rsp(div_rsp),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_data(res)
  );

  assign out_tdata = {res.alpha, res.blue, res.green, res.red};
  assign out_tuser = res.was_filled;

endmodule
